FILE: rtl/core/spr_pkg.sv
// Shared types and constants for the sensor poll and retry controller.
package spr_pkg;

   localparam int unsigned TimeWidth   = 32;
   localparam int unsigned PeriodWidth = 16;
   localparam int unsigned RetryWidth  = 4;
   localparam int unsigned TempWidth   = 16;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned CsrWidth    = 16;

   localparam logic [PeriodWidth-1:0] MinPeriodRst      = 16'd5;
   localparam logic [PeriodWidth-1:0] OutdatedPeriodRst = 16'd60;
   localparam logic [RetryWidth-1:0]  RetryLimitRst     = 4'd3;
   localparam logic [TempWidth-1:0]   InvalidCodeRst    = 16'h7FFF;

   typedef enum logic [1:0] {
      PH_INIT    = 2'd0,
      PH_PENDING = 2'd1,
      PH_READY   = 2'd2,
      PH_ERROR   = 2'd3
   } phase_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_MIN_PERIOD      = 2'd0,
      CSR_OUTDATED_PERIOD = 2'd1,
      CSR_RETRY_LIMIT     = 2'd2,
      CSR_INVALID_CODE    = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [PeriodWidth-1:0]      min_period;
      logic [PeriodWidth-1:0]      outdated_period;
      logic [RetryWidth-1:0]       retry_limit;
      logic signed [TempWidth-1:0] invalid_code;
   } cfg_type;

   typedef struct packed {
      phase_type                   phase;
      logic [RetryWidth-1:0]       retries_left;
      logic [TimeWidth-1:0]        last_good_time;
      logic signed [TempWidth-1:0] cached_temp;
   } state_type;

   typedef struct packed {
      logic [TimeWidth-1:0]        now_sec;
      logic                        init_ok;
      logic                        meas_done;
      logic signed [TempWidth-1:0] meas_value;
   } item_type;

   typedef struct packed {
      logic                        start_meas;
      logic                        temp_valid;
      logic signed [TempWidth-1:0] temperature;
      logic [1:0]                  phase;
   } result_type;

endpackage

FILE: rtl/core/spr_if.sv
// Request and response channel interfaces of the sensor poll controller.
interface spr_req_if;
   import spr_pkg::*;
   logic                        valid;
   logic                        ready;
   logic [TimeWidth-1:0]        now_sec;
   logic                        init_ok;
   logic                        meas_done;
   logic signed [TempWidth-1:0] meas_value;

   modport source (output valid, output now_sec, output init_ok, output meas_done,
                   output meas_value, input ready);
   modport sink   (input valid, input now_sec, input init_ok, input meas_done,
                   input meas_value, output ready);
endinterface

interface spr_rsp_if;
   import spr_pkg::*;
   logic                        valid;
   logic                        ready;
   logic                        start_meas;
   logic                        temp_valid;
   logic signed [TempWidth-1:0] temperature;
   logic [1:0]                  phase;

   modport source (output valid, output start_meas, output temp_valid,
                   output temperature, output phase, input ready);
   modport sink   (input valid, input start_meas, input temp_valid,
                   input temperature, input phase, output ready);
endinterface

FILE: rtl/core/spr_csr.sv
// Configuration register file of the sensor poll controller.
module spr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [spr_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [spr_pkg::CsrWidth-1:0]     csr_wdata,
   output spr_pkg::cfg_type                 cfg
);
   import spr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_MIN_PERIOD:      cfg_in.min_period      = csr_wdata[PeriodWidth-1:0];
            CSR_OUTDATED_PERIOD: cfg_in.outdated_period = csr_wdata[PeriodWidth-1:0];
            CSR_RETRY_LIMIT:     cfg_in.retry_limit     = csr_wdata[RetryWidth-1:0];
            CSR_INVALID_CODE:    cfg_in.invalid_code    = csr_wdata[TempWidth-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_period      <= MinPeriodRst;
         cfg_ff.outdated_period <= OutdatedPeriodRst;
         cfg_ff.retry_limit     <= RetryLimitRst;
         cfg_ff.invalid_code    <= InvalidCodeRst;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/core/spr_step.sv
// Per-poll update: phase transition, retry count, cache and freshness check.
module spr_step (
   input  spr_pkg::cfg_type    cfg,
   input  spr_pkg::state_type  state,
   input  spr_pkg::item_type   item,
   output spr_pkg::state_type  state_next,
   output spr_pkg::result_type result
);
   import spr_pkg::*;

   logic [TimeWidth-1:0] age;
   logic                 good_read;
   logic                 period_over;
   phase_type            phase_in;
   logic                 start;
   logic [RetryWidth-1:0]       retries_in;
   logic [TimeWidth-1:0]        last_in;
   logic signed [TempWidth-1:0] cached_upd;
   logic [TimeWidth-1:0]        age_out;
   logic                        fresh;

   assign age         = item.now_sec - state.last_good_time;
   assign good_read   = item.meas_done && (item.meas_value != cfg.invalid_code);
   assign period_over = age > {{(TimeWidth-PeriodWidth){1'b0}}, cfg.min_period};

   // Next phase
   always_comb begin
      phase_in = state.phase;
      unique case (state.phase)
         PH_INIT:    phase_in = item.init_ok ? PH_PENDING : PH_ERROR;
         PH_PENDING: begin
            if (good_read) begin
               phase_in = PH_READY;
            end else if (item.meas_done && (state.retries_left == '0)) begin
               phase_in = PH_ERROR;
            end
         end
         PH_READY:   if (period_over) phase_in = PH_PENDING;
         PH_ERROR:   phase_in = PH_INIT;
         default:    phase_in = PH_INIT;
      endcase
   end

   // Phase outputs and datapath updates
   always_comb begin
      start      = 1'b0;
      retries_in = state.retries_left;
      last_in    = state.last_good_time;
      cached_upd = state.cached_temp;
      unique case (state.phase)
         PH_INIT: begin
            if (item.init_ok) begin
               start      = 1'b1;
               retries_in = cfg.retry_limit;
            end
         end
         PH_PENDING: begin
            if (good_read) begin
               last_in    = item.now_sec;
               cached_upd = item.meas_value;
               retries_in = cfg.retry_limit;
            end else if (item.meas_done && (state.retries_left != '0)) begin
               retries_in = state.retries_left - 1'b1;
               start      = 1'b1;
            end
         end
         PH_READY: start = period_over;
         PH_ERROR: start = 1'b0;
         default:  start = 1'b0;
      endcase
   end

   // A fresh good reading has zero age; otherwise age is unchanged.
   assign age_out = (state.phase == PH_PENDING && good_read) ? '0 : age;
   assign fresh   = age_out < {{(TimeWidth-PeriodWidth){1'b0}}, cfg.outdated_period};

   always_comb begin
      state_next.phase          = phase_in;
      state_next.retries_left   = retries_in;
      state_next.last_good_time = last_in;
      state_next.cached_temp    = cached_upd;
      result.start_meas  = start;
      result.temp_valid  = 1'b0;
      result.temperature = cfg.invalid_code;
      result.phase       = phase_in;
      if (cached_upd != cfg.invalid_code) begin
         if (fresh) begin
            result.temp_valid  = 1'b1;
            result.temperature = cached_upd;
         end else begin
            state_next.cached_temp = cfg.invalid_code;
         end
      end
   end

endmodule

FILE: rtl/core/sensor_poll_retry_fsm_core.sv
// Top level of the sensor poll and retry controller.
// Path: an accepted request is registered, then moves into the response register when that frees.
// Throughput: one request per cycle while responses drain; the controller state is read and written in the
//    single update stage between the request register and the response register.
// Reset: synchronous, active high; clears both pipeline valids, returns the phase to init,
//    the retry count to 3, the time stamp to 0 and the cache and registers to reset values.
module sensor_poll_retry_fsm_core (
   input  logic                             clock,
   input  logic                             reset,
   spr_req_if.sink                          req_chan,
   spr_rsp_if.source                        rsp_chan,
   input  logic                             csr_we,
   input  logic [spr_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [spr_pkg::CsrWidth-1:0]     csr_wdata
);
   import spr_pkg::*;

   cfg_type    cfg;

   // Request register stage
   logic       req_valid_ff;
   item_type   req_item_ff;

   // Controller state
   state_type  state_ff;
   state_type  state_in;

   // Response register stage
   logic       rsp_valid_ff;
   result_type rsp_data_ff;
   result_type result;

   logic       advance;
   logic       req_take;

   spr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   spr_step u_step (
      .cfg        (cfg),
      .state      (state_ff),
      .item       (req_item_ff),
      .state_next (state_in),
      .result     (result)
   );

   // Advance the registered request into the response slot when that slot is
   // empty or is drained this cycle; the state updates on the same edge.
   assign advance  = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !req_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_take || (req_valid_ff && !advance);
      end
   end

   // Hold the payload until a new request replaces it
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_item_ff.now_sec    <= req_chan.now_sec;
         req_item_ff.init_ok    <= req_chan.init_ok;
         req_item_ff.meas_done  <= req_chan.meas_done;
         req_item_ff.meas_value <= req_chan.meas_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase          <= PH_INIT;
         state_ff.retries_left   <= RetryLimitRst;
         state_ff.last_good_time <= '0;
         state_ff.cached_temp    <= InvalidCodeRst;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.start_meas  = rsp_data_ff.start_meas;
   assign rsp_chan.temp_valid  = rsp_data_ff.temp_valid;
   assign rsp_chan.temperature = rsp_data_ff.temperature;
   assign rsp_chan.phase       = rsp_data_ff.phase;

endmodule

FILE: tb/sv/sensor_poll_retry_fsm_core_tb.sv
// Self-checking testbench for the sensor poll and retry controller core.
module sensor_poll_retry_fsm_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import spr_pkg::*;

   // Generous ceiling; the slowest legal run stays far below it.
   localparam int unsigned CycleLimit = 300000;

   logic clock;
   logic reset;
   logic csr_we;
   csr_idx_type csr_index;
   logic [CsrWidth-1:0] csr_wdata;

   spr_req_if poll_req ();
   spr_rsp_if poll_rsp ();

   sensor_poll_retry_fsm_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (poll_req),
      .rsp_chan  (poll_rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the controller: limits and registered state.
   cfg_type    limits;
   state_type  ctl;
   result_type poll_results_due[$];

   int          mismatches;
   int          send_idle_pct;
   int          rsp_idle_pct;
   int          rsp_hold_cycles;
   int unsigned cycle_count;
   logic [TimeWidth-1:0] now_cursor;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Abort the run if the handshakes stop making progress.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("sensor_poll_retry_fsm_core_tb failed");
         $finish;
      end
   end

   // Advance the shadow controller by one poll and return the response it owes.
   function automatic result_type advance_controller(input item_type poll);
      result_type           rsp;
      logic [TimeWidth-1:0] elapsed;
      rsp.start_meas  = 1'b0;
      rsp.temp_valid  = 1'b0;
      rsp.temperature = limits.invalid_code;
      case (ctl.phase)
         PH_INIT: begin
            // init_ok only matters here
            if (poll.init_ok) begin
               ctl.phase        = PH_PENDING;
               ctl.retries_left = limits.retry_limit;
               rsp.start_meas   = 1'b1;
            end else begin
               ctl.phase = PH_ERROR;
            end
         end
         PH_PENDING: begin
            if (poll.meas_done) begin
               if (poll.meas_value != limits.invalid_code) begin
                  ctl.last_good_time = poll.now_sec;
                  ctl.cached_temp    = poll.meas_value;
                  ctl.retries_left   = limits.retry_limit;
                  ctl.phase          = PH_READY;
               end else if (ctl.retries_left != '0) begin
                  ctl.retries_left = ctl.retries_left - 1'b1;
                  rsp.start_meas   = 1'b1;
               end else begin
                  ctl.phase = PH_ERROR;
               end
            end
         end
         PH_READY: begin
            // elapsed time wraps modulo 2^32, so a clock that runs backwards looks old
            elapsed = poll.now_sec - ctl.last_good_time;
            if (elapsed > TimeWidth'(limits.min_period)) begin
               ctl.phase      = PH_PENDING;
               rsp.start_meas = 1'b1;
            end
         end
         default: ctl.phase = PH_INIT;
      endcase
      // Age the cache after the phase update; drop a stale reading.
      if (ctl.cached_temp != limits.invalid_code) begin
         elapsed = poll.now_sec - ctl.last_good_time;
         if (elapsed < TimeWidth'(limits.outdated_period)) begin
            rsp.temp_valid  = 1'b1;
            rsp.temperature = ctl.cached_temp;
         end else begin
            ctl.cached_temp = limits.invalid_code;
         end
      end
      rsp.phase = ctl.phase;
      return rsp;
   endfunction

   function automatic item_type make_poll(input logic [TimeWidth-1:0] now, input logic ok,
                                          input logic done, input logic [TempWidth-1:0] value);
      item_type poll;
      poll.now_sec    = now;
      poll.init_ok    = ok;
      poll.meas_done  = done;
      poll.meas_value = value;
      return poll;
   endfunction

   // Offer one request, hold it until accepted, then record what it must produce.
   task automatic send_poll(input item_type poll);
      poll_req.valid      <= 1'b1;
      poll_req.now_sec    <= poll.now_sec;
      poll_req.init_ok    <= poll.init_ok;
      poll_req.meas_done  <= poll.meas_done;
      poll_req.meas_value <= poll.meas_value;
      @(posedge clock);
      while (!poll_req.ready) @(posedge clock);
      poll_results_due.push_back(advance_controller(poll));
      // Drop valid for a random run of idle cycles, or keep streaming back to back.
      if ($urandom_range(99) < send_idle_pct) begin
         poll_req.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
   endtask

   // Stop offering requests and wait out every response still owed.
   task automatic drain_polls();
      poll_req.valid <= 1'b0;
      while (poll_results_due.size() != 0) @(posedge clock);
      // the core is two stages deep; let it settle
      repeat (4) @(posedge clock);
   endtask

   // Write one register; only called with the core idle.
   task automatic write_csr(input csr_idx_type idx, input logic [CsrWidth-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_MIN_PERIOD:      limits.min_period      = data;
         CSR_OUTDATED_PERIOD: limits.outdated_period = data;
         CSR_RETRY_LIMIT:     limits.retry_limit     = data[RetryWidth-1:0];
         default:             limits.invalid_code    = data;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_limits(input logic [CsrWidth-1:0] min_p, input logic [CsrWidth-1:0] old_p,
                               input logic [CsrWidth-1:0] retry, input logic [CsrWidth-1:0] bad);
      write_csr(CSR_MIN_PERIOD, min_p);
      write_csr(CSR_OUTDATED_PERIOD, old_p);
      write_csr(CSR_RETRY_LIMIT, retry);
      write_csr(CSR_INVALID_CODE, bad);
   endtask

   // Mostly plausible poll sequences: time creeps forward, sometimes jumps past
   // the request or stale thresholds; a tenth of the polls are pure noise.
   task automatic run_polls(input int count);
      item_type             poll;
      logic [TimeWidth-1:0] step;
      int                   pick;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 10) begin
            poll.now_sec    = $urandom;
            poll.init_ok    = 1'($urandom_range(1));
            poll.meas_done  = 1'($urandom_range(1));
            poll.meas_value = 16'($urandom_range(65535));
         end else begin
            pick = $urandom_range(99);
            if (pick < 70)
               step = $urandom_range(0, 3);
            else if (pick < 85)
               step = limits.min_period + $urandom_range(0, 2);
            else
               step = limits.outdated_period + $urandom_range(0, 2);
            now_cursor      = now_cursor + step;
            poll.now_sec    = now_cursor;
            poll.init_ok    = ($urandom_range(99) < 85);
            poll.meas_done  = ($urandom_range(99) < 60);
            poll.meas_value = ($urandom_range(99) < 30) ? limits.invalid_code
                                                        : 16'($urandom_range(65535));
         end
         send_poll(poll);
      end
   endtask

   // Walk every phase transition under the reset limits, including the wrap of
   // the seconds counter and a clock that steps backwards.
   task automatic test_phase_walk();
      send_poll(make_poll(32'd10, 1'b0, 1'b1, 16'h1234));       // init fails, go to error
      send_poll(make_poll(32'd11, 1'b1, 1'b1, 16'h0000));       // error back to init
      send_poll(make_poll(32'd12, 1'b1, 1'b0, 16'h0000));       // init ok, request
      send_poll(make_poll(32'd13, 1'b0, 1'b0, 16'h0042));       // pending, nothing done
      repeat (3) send_poll(make_poll(32'd14, 1'b0, 1'b1, 16'h7FFF)); // retry each time
      send_poll(make_poll(32'd17, 1'b0, 1'b1, 16'h7FFF));       // retries used up
      send_poll(make_poll(32'd18, 1'b0, 1'b0, 16'h0000));
      send_poll(make_poll(32'd19, 1'b1, 1'b0, 16'h0000));
      send_poll(make_poll(32'd100, 1'b0, 1'b1, 16'h8000));      // most negative reading
      send_poll(make_poll(32'd105, 1'b0, 1'b0, 16'h0000));      // exactly min_period: hold
      send_poll(make_poll(32'd106, 1'b1, 1'b1, 16'h0000));      // past it: request again
      send_poll(make_poll(32'd159, 1'b0, 1'b0, 16'h0000));      // last fresh second
      send_poll(make_poll(32'd160, 1'b0, 1'b0, 16'h0000));      // stale, cache dropped
      send_poll(make_poll(32'd161, 1'b0, 1'b1, 16'h7FFF));
      send_poll(make_poll(32'hFFFF_FFF0, 1'b0, 1'b1, 16'h7FFE)); // good reading near wrap
      send_poll(make_poll(32'h0000_0002, 1'b0, 1'b0, 16'h0000)); // elapsed wraps to 18
      send_poll(make_poll(32'h0000_0003, 1'b0, 1'b1, 16'h0001));
      send_poll(make_poll(32'h0000_0001, 1'b0, 1'b0, 16'h0000)); // time runs backwards
      send_poll(make_poll(32'hFFFF_FFFF, 1'b1, 1'b1, 16'h0000));
      drain_polls();
   endtask

   // Both ends of every limit, then a new invalid code that matches the cache.
   task automatic test_register_extremes();
      write_limits(16'h0000, 16'h0000, 16'h0000, 16'h8000);
      run_polls(40);
      drain_polls();
      write_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
      run_polls(40);
      drain_polls();
      // change the invalid code to whatever is cached right now
      write_csr(CSR_INVALID_CODE, ctl.cached_temp);
      run_polls(10);
      drain_polls();
   endtask

   task automatic test_random_polls(input int phases, input int per_phase);
      for (int p = 0; p < phases; p++) begin
         write_limits(($urandom_range(3) != 0) ? 16'($urandom_range(0, 12))
                                               : 16'($urandom_range(65535)),
                      ($urandom_range(3) != 0) ? 16'($urandom_range(0, 90))
                                               : 16'($urandom_range(65535)),
                      16'($urandom_range(65535)),
                      $urandom_range(1) ? 16'h7FFF : 16'($urandom_range(65535)));
         run_polls(per_phase);
         drain_polls();
      end
   endtask

   // Hold the response side off long enough that the core backs up and stalls
   // its request side, while polls keep coming.
   task automatic test_backpressure();
      send_idle_pct   = 0;
      rsp_hold_cycles = 60;
      run_polls(40);
      drain_polls();
   endtask

   // Check each response against the oldest prediction; drive the response ready.
   task automatic flag_mismatch(input string field, input logic [15:0] want,
                                input logic [15:0] got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         poll_rsp.ready <= 1'b0;
      end else begin
         if (poll_rsp.valid && poll_rsp.ready) begin
            if (poll_results_due.size() == 0) begin
               $display("%0t: response with none outstanding, actual %0h %0h %0h %0h", $time,
                        poll_rsp.start_meas, poll_rsp.temp_valid, poll_rsp.temperature,
                        poll_rsp.phase);
               mismatches++;
            end else begin
               want = poll_results_due.pop_front();
               if (poll_rsp.start_meas !== want.start_meas)
                  flag_mismatch("start_meas", want.start_meas, poll_rsp.start_meas);
               if (poll_rsp.temp_valid !== want.temp_valid)
                  flag_mismatch("temp_valid", want.temp_valid, poll_rsp.temp_valid);
               if (poll_rsp.temperature !== want.temperature)
                  flag_mismatch("temperature", want.temperature, poll_rsp.temperature);
               if (poll_rsp.phase !== want.phase)
                  flag_mismatch("phase", want.phase, poll_rsp.phase);
            end
         end
         // A pending hold-off wins over the random stall pattern.
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            poll_rsp.ready <= 1'b0;
         end else begin
            poll_rsp.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   initial begin
      // Drive every input known before the first edge; hold reset.
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = CSR_MIN_PERIOD;
      csr_wdata           = '0;
      poll_req.valid      = 1'b0;
      poll_req.now_sec    = '0;
      poll_req.init_ok    = 1'b0;
      poll_req.meas_done  = 1'b0;
      poll_req.meas_value = '0;
      poll_rsp.ready      = 1'b0;
      mismatches          = 0;
      cycle_count         = 0;
      rsp_hold_cycles     = 0;
      now_cursor          = $urandom;

      // Shadow state starts from the reset values.
      limits.min_period      = MinPeriodRst;
      limits.outdated_period = OutdatedPeriodRst;
      limits.retry_limit     = RetryLimitRst;
      limits.invalid_code    = InvalidCodeRst;
      ctl.phase              = PH_INIT;
      ctl.retries_left       = RetryLimitRst;
      ctl.last_good_time     = '0;
      ctl.cached_temp        = InvalidCodeRst;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Sender idles lightly, receiver heavily.
      send_idle_pct = 23;
      rsp_idle_pct  = 49;
      test_phase_walk();
      test_register_extremes();
      test_random_polls(2, 100);

      // Swap the idling between the two sides.
      send_idle_pct = 49;
      rsp_idle_pct  = 23;
      test_random_polls(2, 100);

      // Full rate on both sides, then the long receiver stall.
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      test_random_polls(2, 100);
      test_backpressure();

      if (mismatches == 0)
         $display("sensor_poll_retry_fsm_core_tb passed");
      else
         $display("sensor_poll_retry_fsm_core_tb failed");
      $finish;
   end

endmodule
